/* rtl/pfe_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package pfe_pkg;

    // Item kinds carried on the input channel.
    localparam logic [2:0] KIND_SET_LEVEL  = 3'd0;
    localparam logic [2:0] KIND_SET_COLOUR = 3'd1;
    localparam logic [2:0] KIND_TICK       = 3'd2;
    localparam logic [2:0] KIND_ALL_OFF    = 3'd3;
    localparam logic [2:0] KIND_COUNT      = 3'd4;

    localparam logic [7:0]        BRIGHT_MAX   = 8'd255;
    localparam logic signed [7:0] STEP_RAW_MIN = -8'sd128;
    localparam logic signed [7:0] STEP_LOWEST  = -8'sd127;
    localparam logic [6:0]        COUNT_MAX    = 7'd127;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FADE,
        ST_COUNT,
        ST_HOLD
    } state_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } colour_t;

    typedef struct packed {
        logic [7:0]        bright;
        logic signed [7:0] step;
    } level_t;

endpackage

`default_nettype wire

/* rtl/pixel_fade_engine.sv */
`timescale 1ns / 1ps
`default_nettype none

// Pixel fade engine: holds a table of PIXELS LED pixels (colour, brightness and a signed
// fade step, all zero after reset) and takes one word at a time on the s_ channel. Set
// brightness/step, set colour, all off, and a fade tick that does not bring the divider
// to zero are each done as they are taken, and s_ready stays high. A fade tick that
// reaches zero reloads the divider from fade_divider and walks every pixel; s_ready
// stays low until the last pixel has been processed. A count query walks every
// pixel as well and keeps s_ready low through the walk and the hold state, then leaves
// its answer in the m_ output register, where it may wait while new words are taken; a
// second query waits in the hold state until the previous answer has gone. Both walks
// are set by the single read port of the pixel memory, one pixel per cycle, feeding one
// shared update/compare unit. Writing the divider register leaves the running tick
// count alone: the new value is used at the next reload.

module pixel_fade_engine #(
    parameter int PIXELS = 64
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,

    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [7:0]        cfg_fade_divider,

    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [2:0]        s_kind,
    input  wire logic [5:0]        s_pixel_index,
    input  wire logic [7:0]        s_brightness,
    input  wire logic signed [7:0] s_fade_step,
    input  wire logic [7:0]        s_red,
    input  wire logic [7:0]        s_green,
    input  wire logic [7:0]        s_blue,

    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [6:0]             m_lit_count
);

    localparam int IDX_W = (PIXELS > 1) ? $clog2(PIXELS) : 1;

    // Control state.
    pfe_pkg::state_t   state_reg, state_next;
    logic [IDX_W-1:0]  rd_idx_reg, rd_idx_next;
    logic              issue_reg, issue_next;
    logic [6:0]        cnt_reg, cnt_next;
    logic [7:0]        tick_reg, tick_next;
    logic [7:0]        fade_div_reg, fade_div_next;
    logic              m_valid_reg, m_valid_next;
    logic [6:0]        m_count_reg, m_count_next;

    // Valid bits: an entry that was never written reads as zero.
    logic [PIXELS-1:0] cval_reg, cval_next;
    logic [PIXELS-1:0] bval_reg, bval_next;

    // Read pipeline stage that follows the memory read.
    logic              pipe_vld_reg;
    logic              pipe_last_reg;
    logic [IDX_W-1:0]  pipe_idx_reg;
    logic              pipe_cv_reg;
    logic              pipe_bv_reg;
    pfe_pkg::colour_t  col_rdata_reg;
    pfe_pkg::level_t   lvl_rdata_reg;

    // Pixel memories.
    pfe_pkg::colour_t  col_mem [PIXELS];
    pfe_pkg::level_t   lvl_mem [PIXELS];

    logic              col_we;
    pfe_pkg::colour_t  col_wdata;
    logic              lvl_we;
    logic [IDX_W-1:0]  lvl_waddr;
    pfe_pkg::level_t   lvl_wdata;

    logic [IDX_W-1:0]  set_addr;
    logic              set_in_range;
    logic              rd_last;
    logic [7:0]        tick_dec;

    // Shared unit signals.
    pfe_pkg::colour_t  cur_col;
    pfe_pkg::level_t   cur_lvl;
    pfe_pkg::level_t   upd_lvl;
    logic [7:0]        step_mag;
    logic [8:0]        bright_sum;
    logic [7:0]        chan_max;
    logic [16:0]       lit_prod;
    logic              pix_lit;

    assign cfg_ready   = 1'b1;
    assign s_ready     = (state_reg == pfe_pkg::ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_lit_count = m_count_reg;

    assign set_addr     = IDX_W'(s_pixel_index);
    assign set_in_range = (int'(s_pixel_index) < PIXELS);
    assign rd_last      = (rd_idx_reg == IDX_W'(PIXELS - 1));
    assign tick_dec     = tick_reg - 8'd1;

    // Entries whose valid bit is clear behave as all zero.
    assign cur_col = pipe_cv_reg ? col_rdata_reg : '0;
    assign cur_lvl = pipe_bv_reg ? lvl_rdata_reg : '0;

    // Fade update of one pixel. The step is never -128, so its negation fits.
    always_comb begin
        step_mag   = 8'(-cur_lvl.step);
        bright_sum = {1'b0, cur_lvl.bright} + {1'b0, step_mag};
        upd_lvl    = cur_lvl;
        if (cur_lvl.step < 0) begin
            if (bright_sum[8]) begin
                upd_lvl.bright = pfe_pkg::BRIGHT_MAX;
                upd_lvl.step   = signed'(step_mag);
            end else begin
                upd_lvl.bright = bright_sum[7:0];
            end
        end else begin
            if (cur_lvl.bright >= unsigned'(cur_lvl.step)) begin
                upd_lvl.bright = cur_lvl.bright - unsigned'(cur_lvl.step);
            end else begin
                upd_lvl.bright = '0;
            end
        end
    end

    // A pixel is lit when its largest channel times (brightness+1) reaches 256.
    always_comb begin
        chan_max = cur_col.red;
        if (cur_col.green > chan_max) begin
            chan_max = cur_col.green;
        end
        if (cur_col.blue > chan_max) begin
            chan_max = cur_col.blue;
        end
        lit_prod = 17'(chan_max) * 17'({1'b0, cur_lvl.bright} + 9'd1);
        pix_lit  = |lit_prod[16:8];
    end

    always_comb begin
        state_next    = state_reg;
        rd_idx_next   = rd_idx_reg;
        issue_next    = issue_reg;
        cnt_next      = cnt_reg;
        tick_next     = tick_reg;
        fade_div_next = fade_div_reg;
        m_valid_next  = m_valid_reg;
        m_count_next  = m_count_reg;
        cval_next     = cval_reg;
        bval_next     = bval_reg;
        col_we        = 1'b0;
        col_wdata     = '{red: s_red, green: s_green, blue: s_blue};
        lvl_we        = 1'b0;
        lvl_waddr     = set_addr;
        lvl_wdata.bright = s_brightness;
        lvl_wdata.step   = (s_fade_step == pfe_pkg::STEP_RAW_MIN) ?
                           pfe_pkg::STEP_LOWEST : s_fade_step;

        if (cfg_valid) begin
            fade_div_next = cfg_fade_divider;
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        // Read issue side of the walk.
        if (issue_reg) begin
            if (rd_last) begin
                issue_next = 1'b0;
            end else begin
                rd_idx_next = rd_idx_reg + IDX_W'(1);
            end
        end

        case (state_reg)
            pfe_pkg::ST_IDLE: begin
                if (s_valid) begin
                    case (s_kind)
                        pfe_pkg::KIND_SET_LEVEL: begin
                            if (set_in_range) begin
                                lvl_we              = 1'b1;
                                bval_next[set_addr] = 1'b1;
                            end
                        end
                        pfe_pkg::KIND_SET_COLOUR: begin
                            if (set_in_range) begin
                                col_we              = 1'b1;
                                cval_next[set_addr] = 1'b1;
                            end
                        end
                        pfe_pkg::KIND_TICK: begin
                            tick_next = tick_dec;
                            if (tick_dec == 8'd0) begin
                                tick_next   = fade_div_reg;
                                state_next  = pfe_pkg::ST_FADE;
                                issue_next  = 1'b1;
                                rd_idx_next = '0;
                            end
                        end
                        pfe_pkg::KIND_ALL_OFF: begin
                            // Brightness and step go to zero; colours stay.
                            bval_next = '0;
                        end
                        pfe_pkg::KIND_COUNT: begin
                            state_next  = pfe_pkg::ST_COUNT;
                            issue_next  = 1'b1;
                            rd_idx_next = '0;
                            cnt_next    = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            pfe_pkg::ST_FADE: begin
                if (pipe_vld_reg) begin
                    if (pipe_bv_reg) begin
                        lvl_we    = 1'b1;
                        lvl_waddr = pipe_idx_reg;
                        lvl_wdata = upd_lvl;
                    end
                    if (pipe_last_reg) begin
                        state_next = pfe_pkg::ST_IDLE;
                    end
                end
            end
            pfe_pkg::ST_COUNT: begin
                if (pipe_vld_reg) begin
                    if (pix_lit && (cnt_reg != pfe_pkg::COUNT_MAX)) begin
                        cnt_next = cnt_reg + 7'd1;
                    end
                    if (pipe_last_reg) begin
                        state_next = pfe_pkg::ST_HOLD;
                    end
                end
            end
            pfe_pkg::ST_HOLD: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_count_next = cnt_reg;
                    state_next   = pfe_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pfe_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= pfe_pkg::ST_IDLE;
            rd_idx_reg    <= '0;
            issue_reg     <= 1'b0;
            cnt_reg       <= '0;
            tick_reg      <= 8'd4;
            fade_div_reg  <= 8'd4;
            m_valid_reg   <= 1'b0;
            cval_reg      <= '0;
            bval_reg      <= '0;
            pipe_vld_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            rd_idx_reg    <= rd_idx_next;
            issue_reg     <= issue_next;
            cnt_reg       <= cnt_next;
            tick_reg      <= tick_next;
            fade_div_reg  <= fade_div_next;
            m_valid_reg   <= m_valid_next;
            cval_reg      <= cval_next;
            bval_reg      <= bval_next;
            pipe_vld_reg  <= issue_reg;
        end
    end

    always_ff @(posedge aclk) begin
        m_count_reg   <= m_count_next;
        pipe_last_reg <= rd_last;
        pipe_idx_reg  <= rd_idx_reg;
        if (issue_reg) begin
            pipe_cv_reg <= cval_reg[rd_idx_reg];
            pipe_bv_reg <= bval_reg[rd_idx_reg];
        end
    end

    // Colour memory.
    always_ff @(posedge aclk) begin
        if (col_we) begin
            col_mem[set_addr] <= col_wdata;
        end
        if (issue_reg) begin
            col_rdata_reg <= col_mem[rd_idx_reg];
        end
    end

    // Brightness and step memory.
    always_ff @(posedge aclk) begin
        if (lvl_we) begin
            lvl_mem[lvl_waddr] <= lvl_wdata;
        end
        if (issue_reg) begin
            lvl_rdata_reg <= lvl_mem[rd_idx_reg];
        end
    end

    // A result only appears out of the hold state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == pfe_pkg::ST_HOLD))
        else $error("result raised outside the hold state");

    // The walk pipeline runs only during a fade or a count.
    assert property (@(posedge aclk) disable iff (!aresetn)
        pipe_vld_reg |-> (state_reg == pfe_pkg::ST_FADE || state_reg == pfe_pkg::ST_COUNT))
        else $error("pixel read in flight outside a walk");

    // Reads stay inside the table.
    assert property (@(posedge aclk) disable iff (!aresetn)
        issue_reg |-> (int'(rd_idx_reg) < PIXELS))
        else $error("pixel read beyond the table");

    // Once in hold, the walk has drained completely.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == pfe_pkg::ST_HOLD) |-> (!issue_reg && !pipe_vld_reg))
        else $error("hold entered with reads still pending");

    // The count never exceeds the table size.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (int'(m_count_reg) <= PIXELS))
        else $error("lit count larger than the table");

endmodule

`default_nettype wire
